[hdl/vser_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex set rotator package
// Shared types, constants and small tables for the vertex rotator.
// ----------------------------------------------------------------------------
package vser_pkg;

   localparam int NUM_VERTICES   = 8;
   localparam int VIDX_W         = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int TRIG_FRAC_BITS = 30;
   localparam int RND_SH         = 62 - TRIG_FRAC_BITS;
   localparam int NUM_STEPS      = 21;

   localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(NUM_VERTICES - 1);

   // pi/2 in Q1.63, split into halves for the 32-bit multiplier
   localparam logic [31:0] HALF_PI_HI = 32'hC90FDAA2;
   localparam logic [31:0] HALF_PI_LO = 32'h2168C235;
   localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;

   localparam logic [31:0] CUBE_LO = 32'd16384000;   // 250.0 in Q16.16
   localparam logic [31:0] CUBE_HI = 32'd49152000;   // 750.0 in Q16.16

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vtx_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] sin;
      logic signed [31:0] cos;
   } trig_rsp_type;

   typedef enum logic [2:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_SPEED_X  = 3'd3,
      CSR_SPEED_Y  = 3'd4,
      CSR_SPEED_Z  = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      AX_Z = 2'd0,
      AX_X = 2'd1,
      AX_Y = 2'd2
   } axis_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TSTART,
      S_TWAIT,
      S_RD,
      S_DIFF,
      S_MUL,
      S_WR,
      S_ORD,
      S_OCAP,
      S_OUT
   } st_type;

   typedef enum logic [3:0] {
      T_IDLE,
      T_ANG,
      T_RED,
      T_XHI,
      T_XLO,
      T_XSUM,
      T_MQ,
      T_DIV,
      T_UPD,
      T_RND
   } trig_st_type;

   // cube corner that a vertex holds until first loaded
   function automatic vtx_type cube_vertex(input logic [VIDX_W-1:0] idx);
      int      k;
      vtx_type v;
      k   = int'(idx) % 8;
      v.x = (k == 0 || k == 3 || k == 4 || k == 7) ? CUBE_LO : CUBE_HI;
      v.y = (k == 0 || k == 1 || k == 4 || k == 5) ? CUBE_LO : CUBE_HI;
      v.z = (k < 4) ? (32'd0 - CUBE_LO) : CUBE_LO;
      return v;
   endfunction

   // series step j covers order n = j + 1: odd n feeds cosine, even n sine
   function automatic logic [8:0] step_div(input logic [4:0] j);
      int n;
      n = int'(j) + 1;
      return 9'(n * (n + 1));
   endfunction

   function automatic logic step_sub(input logic [4:0] j);
      int n;
      n = int'(j) + 1;
      return 1'(((n + 1) >> 1) & 1);
   endfunction

   function automatic logic step_cos(input logic [4:0] j);
      return ~j[0];
   endfunction

endpackage

[hdl/vser_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registered multiplier
// Signed 34 x 34 multiply with the product registered.
// ----------------------------------------------------------------------------
module vser_mul (
   input  logic               clock,
   input  logic signed [33:0] mul_a,
   input  logic signed [33:0] mul_b,
   output logic signed [67:0] mul_p
);

   logic signed [67:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
   end

   assign mul_p = p_ff;

endmodule

[hdl/vser_vram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex memory
// One write and one registered read port; entries never written read as
// their cube corner.
// ----------------------------------------------------------------------------
module vser_vram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [vser_pkg::VIDX_W-1:0] wr_addr,
   input  vser_pkg::vtx_type           wr_data,
   input  logic                        rd_en,
   input  logic [vser_pkg::VIDX_W-1:0] rd_addr,
   output vser_pkg::vtx_type           rd_data
);
   import vser_pkg::*;

   vtx_type                 mem_ff [NUM_VERTICES];
   logic [NUM_VERTICES-1:0] vld_ff;
   vtx_type                 rd_ff;
   logic                    rd_vld_ff;
   logic [VIDX_W-1:0]       rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff      <= mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : cube_vertex(rd_addr_ff);

endmodule

[hdl/vser_trig.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine sequencer
// Angle from elapsed time and speed, octant reduction, Taylor series in
// Q2.62 on a shared multiplier and a four-bit-a-cycle constant divider.
// ----------------------------------------------------------------------------
module vser_trig (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [15:0]            angle_dt,
   input  logic [31:0]            angle_speed,
   output vser_pkg::trig_rsp_type trig_rsp
);
   import vser_pkg::*;

   trig_st_type st_ff, st_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [4:0]   j_ff, j_in;
   logic         x2ph_ff, x2ph_in;
   logic         done_ff, done_in;
   logic [15:0]  dt_ff, dt_in;
   logic [31:0]  spd_ff, spd_in;
   logic [1:0]   q_ff, q_in;
   logic         swap_ff, swap_in;
   logic [29:0]  r_ff, r_in;
   logic [63:0]  x_ff, x_in;
   logic [63:0]  x2_ff, x2_in;
   logic [63:0]  sacc_ff, sacc_in;
   logic [63:0]  cacc_ff, cacc_in;
   logic [63:0]  sterm_ff, sterm_in;
   logic [63:0]  cterm_ff, cterm_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  quo_ff, quo_in;
   logic [8:0]   rem_ff, rem_in;
   logic signed [31:0] sin_ff, sin_in;
   logic signed [31:0] cos_ff, cos_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic [63:0]        p64;
   logic [127:0]       acc_sum;
   logic [1:0]         part;
   logic [63:0]        op_a, op_b;
   logic [63:0]        div_q;
   logic [8:0]         div_r;

   vser_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign p64 = mul_p[63:0];

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         T_IDLE:  if (start) st_in = T_ANG;
         T_ANG:   st_in = T_RED;
         T_RED:   st_in = T_XHI;
         T_XHI:   st_in = T_XLO;
         T_XLO:   st_in = T_XSUM;
         T_XSUM:  st_in = T_MQ;
         T_MQ:    if (cnt_ff == 4'd4) st_in = x2ph_ff ? T_MQ : T_DIV;
         T_DIV:   if (cnt_ff == 4'd15) st_in = T_UPD;
         T_UPD:   st_in = (j_ff == 5'(NUM_STEPS - 1)) ? T_RND : T_MQ;
         T_RND:   st_in = T_IDLE;
         default: st_in = T_IDLE;
      endcase
   end

   // multiplier operands: a Q2.62 product is four 32-bit partials
   always_comb begin
      op_a  = x2ph_ff ? x_ff : (step_cos(j_ff) ? cterm_ff : sterm_ff);
      op_b  = x2ph_ff ? x_ff : x2_ff;
      mul_a = '0;
      mul_b = '0;
      case (st_ff)
         T_ANG: begin
            mul_a = {18'd0, dt_ff};
            mul_b = {2'd0, spd_ff};
         end
         T_XHI: begin
            mul_a = {4'd0, r_ff};
            mul_b = {2'd0, HALF_PI_HI};
         end
         T_XLO: begin
            mul_a = {4'd0, r_ff};
            mul_b = {2'd0, HALF_PI_LO};
         end
         T_MQ: begin
            mul_a = {2'd0, cnt_ff[1] ? op_a[63:32] : op_a[31:0]};
            mul_b = {2'd0, cnt_ff[0] ? op_b[63:32] : op_b[31:0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // weight the partial issued in the previous cycle
   always_comb begin
      part = 2'(cnt_ff - 4'd1);
      case (part)
         2'd0:    acc_sum = acc_ff + {64'd0, p64};
         2'd3:    acc_sum = acc_ff + {p64, 64'd0};
         default: acc_sum = acc_ff + {32'd0, p64, 32'd0};
      endcase
   end

   // restoring division by the series constant, four quotient bits a cycle
   always_comb begin
      logic [9:0]  r10;
      logic [63:0] qv;
      logic [8:0]  dv;
      dv  = step_div(j_ff);
      r10 = {1'b0, rem_ff};
      qv  = quo_ff;
      for (int k = 0; k < 4; k++) begin
         r10 = {r10[8:0], qv[63]};
         qv  = {qv[62:0], 1'b0};
         if (r10 >= {1'b0, dv}) begin
            r10   = r10 - {1'b0, dv};
            qv[0] = 1'b1;
         end
      end
      div_q = qv;
      div_r = r10[8:0];
   end

   // datapath
   always_comb begin
      logic [31:0]        t;
      logic [63:0]        rs64, rc64;
      logic signed [31:0] rs, rc, s_r, c_r;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      x2ph_in  = x2ph_ff;
      done_in  = 1'b0;
      dt_in    = dt_ff;
      spd_in   = spd_ff;
      q_in     = q_ff;
      swap_in  = swap_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      sacc_in  = sacc_ff;
      cacc_in  = cacc_ff;
      sterm_in = sterm_ff;
      cterm_in = cterm_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      t        = p64[31:0];
      rs64     = (sacc_ff + (64'd1 << (RND_SH - 1))) >> RND_SH;
      rc64     = (cacc_ff + (64'd1 << (RND_SH - 1))) >> RND_SH;
      rs       = rs64[31:0];
      rc       = rc64[31:0];
      s_r      = swap_ff ? rc : rs;
      c_r      = swap_ff ? rs : rc;
      case (st_ff)
         T_IDLE: begin
            dt_in  = angle_dt;
            spd_in = angle_speed;
         end
         T_RED: begin
            q_in    = t[31:30];
            swap_in = (t[29:0] > 30'h2000_0000);
            r_in    = (t[29:0] > 30'h2000_0000) ? (30'h0 - t[29:0]) : t[29:0];
         end
         T_XLO: begin
            x_in = {p64[62:0], 1'b0};
         end
         T_XSUM: begin
            x_in     = x_ff + (p64 >> 31);
            sacc_in  = x_ff + (p64 >> 31);
            sterm_in = x_ff + (p64 >> 31);
            cacc_in  = ONE_Q62;
            cterm_in = ONE_Q62;
            x2ph_in  = 1'b1;
            cnt_in   = '0;
            acc_in   = '0;
         end
         T_MQ: begin
            if (cnt_ff != 4'd0) begin
               acc_in = acc_sum;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd4) begin
               cnt_in = '0;
               acc_in = '0;
               if (x2ph_ff) begin
                  x2_in   = acc_sum[125:62];
                  x2ph_in = 1'b0;
                  j_in    = '0;
               end else begin
                  quo_in = acc_sum[125:62];
                  rem_in = '0;
               end
            end
         end
         T_DIV: begin
            quo_in = div_q;
            rem_in = div_r;
            cnt_in = cnt_ff + 4'd1;
         end
         T_UPD: begin
            if (step_cos(j_ff)) begin
               cterm_in = quo_ff;
               cacc_in  = step_sub(j_ff) ? (cacc_ff - quo_ff) : (cacc_ff + quo_ff);
            end else begin
               sterm_in = quo_ff;
               sacc_in  = step_sub(j_ff) ? (sacc_ff - quo_ff) : (sacc_ff + quo_ff);
            end
            j_in   = j_ff + 5'd1;
            cnt_in = '0;
            acc_in = '0;
         end
         T_RND: begin
            done_in = 1'b1;
            case (q_ff)
               2'd0: begin
                  sin_in = s_r;
                  cos_in = c_r;
               end
               2'd1: begin
                  sin_in = c_r;
                  cos_in = -s_r;
               end
               2'd2: begin
                  sin_in = -s_r;
                  cos_in = -c_r;
               end
               default: begin
                  sin_in = -c_r;
                  cos_in = s_r;
               end
            endcase
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= T_IDLE;
         cnt_ff  <= '0;
         j_ff    <= '0;
         x2ph_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         j_ff    <= (j_in >= 5'(NUM_STEPS)) ? 5'(NUM_STEPS - 1) : j_in;
         x2ph_ff <= x2ph_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      spd_ff   <= spd_in;
      q_ff     <= q_in;
      swap_ff  <= swap_in;
      r_ff     <= r_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      sacc_ff  <= sacc_in;
      cacc_ff  <= cacc_in;
      sterm_ff <= sterm_in;
      cterm_ff <= cterm_in;
      acc_ff   <= acc_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
   end

   assign trig_rsp.done = done_ff;
   assign trig_rsp.sin  = sin_ff;
   assign trig_rsp.cos  = cos_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("trig done held for more than one cycle");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      j_ff < 5'(NUM_STEPS))
      else $error("series step out of range");

   a_mq_count: assert property (@(posedge clock) disable iff (reset)
      (st_ff == T_MQ) |-> (cnt_ff <= 4'd4))
      else $error("partial product count out of range");

   a_rnd_done: assert property (@(posedge clock) disable iff (reset)
      (st_ff == T_RND) |=> done_ff)
      else $error("rounding did not signal done");

endmodule

[hdl/vertex_set_euler_rotator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex set Euler rotator
// Rotates stored vertices about a centre on each tick item, z then x then y.
// ----------------------------------------------------------------------------
// Load item: written to vertex memory when taken, no result.
// Tick item: each axis first runs the sine/cosine series on the trig
// sequencer, then reads each vertex, does four multiplies and writes it back.
// One item at a time; results are read back from memory and held until
// rsp_ready, and no new item is taken until the last result has left.
// Reset restores centre and speed registers and the cube corner vertices.
module vertex_set_euler_rotator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [2:0]  req_vertex_index,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_z,
   input  logic [15:0] req_time_delta_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_index,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic        rsp_last_vertex,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import vser_pkg::*;

   st_type             st_ff, st_in;
   axis_type           axis_ff, axis_in;
   logic [VIDX_W-1:0]  vidx_ff, vidx_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [32:0] da_ff, da_in;
   logic signed [32:0] db_ff, db_in;
   logic [63:0]        acca_ff, acca_in;
   logic [63:0]        accb_ff, accb_in;
   vtx_type            vtx_ff, vtx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_idx_ff, rsp_idx_in;
   vtx_type            rsp_vtx_ff, rsp_vtx_in;
   logic               rsp_last_ff, rsp_last_in;
   logic signed [31:0] cen_x_ff, cen_y_ff, cen_z_ff;
   logic [31:0]        spd_x_ff, spd_y_ff, spd_z_ff;

   logic               req_acc;
   logic               trig_start;
   logic [31:0]        trig_speed;
   trig_rsp_type       trig_rsp;
   logic               wr_en, rd_en;
   logic [VIDX_W-1:0]  wr_addr;
   vtx_type            wr_data, rd_data;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic signed [31:0] ca, cb, rd_a, rd_b, new_a, new_b;

   assign req_ready = (st_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   vser_trig u_trig (
      .clock       (clock),
      .reset       (reset),
      .start       (trig_start),
      .angle_dt    (dt_ff),
      .angle_speed (trig_speed),
      .trig_rsp    (trig_rsp)
   );

   vser_vram u_vram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (vidx_ff),
      .rd_data (rd_data)
   );

   vser_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // axis routing: rotated pair and its centre
   always_comb begin
      case (axis_ff)
         AX_Z: begin
            ca = cen_x_ff; cb = cen_y_ff;
            rd_a = rd_data.x; rd_b = rd_data.y;
            trig_speed = spd_z_ff;
         end
         AX_X: begin
            ca = cen_y_ff; cb = cen_z_ff;
            rd_a = rd_data.y; rd_b = rd_data.z;
            trig_speed = spd_x_ff;
         end
         default: begin
            ca = cen_z_ff; cb = cen_x_ff;
            rd_a = rd_data.z; rd_b = rd_data.x;
            trig_speed = spd_y_ff;
         end
      endcase
      new_a = acca_ff[TRIG_FRAC_BITS+31:TRIG_FRAC_BITS] + ca;
      new_b = accb_ff[TRIG_FRAC_BITS+31:TRIG_FRAC_BITS] + cb;
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE:   if (req_acc && req_type) st_in = S_TSTART;
         S_TSTART: st_in = S_TWAIT;
         S_TWAIT:  if (trig_rsp.done) st_in = S_RD;
         S_RD:     st_in = S_DIFF;
         S_DIFF:   st_in = S_MUL;
         S_MUL:    if (cnt_ff == 3'd4) st_in = S_WR;
         S_WR: begin
            if (vidx_ff != LAST_IDX) st_in = S_RD;
            else if (axis_ff == AX_Y) st_in = S_ORD;
            else st_in = S_TSTART;
         end
         S_ORD:    st_in = S_OCAP;
         S_OCAP:   st_in = S_OUT;
         S_OUT: begin
            if (rsp_ready) st_in = (vidx_ff == LAST_IDX) ? S_IDLE : S_ORD;
         end
         default:  st_in = S_IDLE;
      endcase
   end

   // outputs to memory, trig unit and multiplier
   always_comb begin
      trig_start = (st_ff == S_TSTART);
      rd_en      = (st_ff == S_RD) || (st_ff == S_ORD);
      wr_en      = 1'b0;
      wr_addr    = vidx_ff;
      wr_data    = vtx_ff;
      mul_a      = '0;
      mul_b      = '0;
      if (st_ff == S_IDLE && req_acc && !req_type &&
          int'(req_vertex_index) < NUM_VERTICES) begin
         wr_en   = 1'b1;
         wr_addr = VIDX_W'(req_vertex_index);
         wr_data = '{x: req_load_x, y: req_load_y, z: req_load_z};
      end
      if (st_ff == S_WR) begin
         wr_en = 1'b1;
         case (axis_ff)
            AX_Z: begin
               wr_data.x = new_a; wr_data.y = new_b;
            end
            AX_X: begin
               wr_data.y = new_a; wr_data.z = new_b;
            end
            default: begin
               wr_data.z = new_a; wr_data.x = new_b;
            end
         endcase
      end
      if (st_ff == S_MUL) begin
         // issue da*c, db*s, da*s, db*c
         mul_a = cnt_ff[0] ? {db_ff[32], db_ff} : {da_ff[32], da_ff};
         mul_b = (cnt_ff[0] ^ cnt_ff[1]) ?
                 {{2{trig_rsp.sin[31]}}, trig_rsp.sin} :
                 {{2{trig_rsp.cos[31]}}, trig_rsp.cos};
         if (cnt_ff[1]) begin
            mul_b = cnt_ff[0] ? {{2{trig_rsp.cos[31]}}, trig_rsp.cos} :
                                {{2{trig_rsp.sin[31]}}, trig_rsp.sin};
         end
      end
   end

   // datapath registers
   always_comb begin
      axis_in      = axis_ff;
      vidx_in      = vidx_ff;
      cnt_in       = cnt_ff;
      dt_in        = dt_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      acca_in      = acca_ff;
      accb_in      = accb_ff;
      vtx_in       = vtx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_vtx_in   = rsp_vtx_ff;
      rsp_last_in  = rsp_last_ff;
      case (st_ff)
         S_IDLE: begin
            if (req_acc && req_type) begin
               dt_in   = req_time_delta_ms;
               axis_in = AX_Z;
            end
         end
         S_TWAIT: begin
            vidx_in = '0;
         end
         S_DIFF: begin
            vtx_in = rd_data;
            da_in  = 33'(rd_a) - 33'(ca);
            db_in  = 33'(rd_b) - 33'(cb);
            cnt_in = '0;
         end
         S_MUL: begin
            // a' = da*c - db*s, b' = da*s + db*c
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd1:    acca_in = mul_p[63:0];
               3'd2:    acca_in = acca_ff - mul_p[63:0];
               3'd3:    accb_in = mul_p[63:0];
               3'd4:    accb_in = accb_ff + mul_p[63:0];
               default: acca_in = acca_ff;
            endcase
         end
         S_WR: begin
            if (vidx_ff != LAST_IDX) begin
               vidx_in = vidx_ff + 1'b1;
            end else begin
               vidx_in = '0;
               if (axis_ff == AX_Z) axis_in = AX_X;
               else if (axis_ff == AX_X) axis_in = AX_Y;
            end
         end
         S_OCAP: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = 3'(vidx_ff);
            rsp_vtx_in   = rd_data;
            rsp_last_in  = (vidx_ff == LAST_IDX);
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (vidx_ff != LAST_IDX) vidx_in = vidx_ff + 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         axis_ff      <= AX_Z;
         vidx_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cen_x_ff     <= 32'sd32768000;
         cen_y_ff     <= 32'sd32768000;
         cen_z_ff     <= '0;
         spd_x_ff     <= 32'd214748;
         spd_y_ff     <= 32'd644245;
         spd_z_ff     <= 32'd429497;
      end else begin
         st_ff        <= st_in;
         axis_ff      <= axis_in;
         vidx_ff      <= vidx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: cen_x_ff <= csr_data;
               CSR_CENTER_Y: cen_y_ff <= csr_data;
               CSR_CENTER_Z: cen_z_ff <= csr_data;
               CSR_SPEED_X:  spd_x_ff <= csr_data;
               CSR_SPEED_Y:  spd_y_ff <= csr_data;
               CSR_SPEED_Z:  spd_z_ff <= csr_data;
               default:      cen_x_ff <= cen_x_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      acca_ff     <= acca_in;
      accb_ff     <= accb_in;
      vtx_ff      <= vtx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_vtx_ff  <= rsp_vtx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_index   = rsp_idx_ff;
   assign rsp_out_x       = rsp_vtx_ff.x;
   assign rsp_out_y       = rsp_vtx_ff.y;
   assign rsp_out_z       = rsp_vtx_ff.z;
   assign rsp_last_vertex = rsp_last_ff;

   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (st_ff == S_OUT))
      else $error("result shown outside the output state");

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff)
      else $error("input taken while a result is pending");

   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("vertex read and write in the same cycle");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_idx_ff == 3'(LAST_IDX)))
      else $error("last flag on a vertex other than the final one");

endmodule

[tb/vertex_rotation_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex rotation checker
// Watches the request, result and register channels of the vertex rotator,
// keeps its own copy of vertices, centre and speeds, and works out the eight
// rotated vertices of every tick item. Each result is compared field by
// field with the oldest expected vertex; mismatches are counted.
// ----------------------------------------------------------------------------
module vertex_rotation_checker
   import vser_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_type,
   input  logic [2:0]         req_vertex_index,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_z,
   input  logic [15:0]        req_time_delta_ms,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_out_index,
   input  logic signed [31:0] rsp_out_x,
   input  logic signed [31:0] rsp_out_y,
   input  logic signed [31:0] rsp_out_z,
   input  logic               rsp_last_vertex,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);

   localparam logic REQ_TICK = 1'b1;

   typedef struct {
      logic [2:0]         idx;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               last;
   } vertex_rsp_type;

   logic signed [31:0] vx [NUM_VERTICES];
   logic signed [31:0] vy [NUM_VERTICES];
   logic signed [31:0] vz [NUM_VERTICES];
   logic signed [31:0] cen_x, cen_y, cen_z;
   logic [31:0]        spd_x, spd_y, spd_z;
   vertex_rsp_type     rotated_q[$];

   assign pending = rotated_q.size();

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // sine and cosine of t turns, rounded to Q2.30
   function automatic void sin_cos(input logic [31:0] t, output logic signed [63:0] so,
                                   output logic signed [63:0] co);
      logic [63:0] r, x, x2, term, s, c, rs, rc, tv;
      logic        swp;
      r   = {34'd0, t[29:0]};
      swp = r > 64'd536870912;
      if (swp) begin
         r = 64'd1073741824 - r;
      end
      x  = r * 64'(HALF_PI_HI) * 64'd2 + ((r * 64'(HALF_PI_LO)) >> 31);
      x2 = mul_q62(x, x);
      s    = x;
      term = x;
      for (int n = 2; n <= 20; n += 2) begin
         term = mul_q62(term, x2) / 64'(n * (n + 1));
         if (((n / 2) & 1) != 0) s = s - term; else s = s + term;
      end
      c    = ONE_Q62;
      term = ONE_Q62;
      for (int n = 1; n <= 21; n += 2) begin
         term = mul_q62(term, x2) / 64'(n * (n + 1));
         if ((((n + 1) / 2) & 1) != 0) c = c - term; else c = c + term;
      end
      rs = (s + (64'd1 << (RND_SH - 1))) >> RND_SH;
      rc = (c + (64'd1 << (RND_SH - 1))) >> RND_SH;
      if (swp) begin
         tv = rs;
         rs = rc;
         rc = tv;
      end
      case (t[31:30])
         2'd0: begin so = rs;  co = rc;  end
         2'd1: begin so = rc;  co = -rs; end
         2'd2: begin so = -rs; co = -rc; end
         default: begin so = -rc; co = rs; end
      endcase
   endfunction

   // a' = da*c - db*s, b' = da*s + db*c, about (ca, cb)
   function automatic void turn_pair(inout logic signed [31:0] a, inout logic signed [31:0] b,
                                     input logic signed [31:0] ca,
                                     input logic signed [31:0] cb,
                                     input logic signed [63:0] s,
                                     input logic signed [63:0] c);
      logic signed [95:0] da, db, na, nb;
      da = 96'(a) - 96'(ca);
      db = 96'(b) - 96'(cb);
      na = ((da * 96'(c) - db * 96'(s)) >>> TRIG_FRAC_BITS) + 96'(ca);
      nb = ((da * 96'(s) + db * 96'(c)) >>> TRIG_FRAC_BITS) + 96'(cb);
      a  = na[31:0];
      b  = nb[31:0];
   endfunction

   task automatic rotate_all(input logic [15:0] dt);
      logic signed [63:0] s, c;
      vertex_rsp_type     e;
      sin_cos(32'(64'(dt) * 64'(spd_z)), s, c);
      for (int i = 0; i < NUM_VERTICES; i++) turn_pair(vx[i], vy[i], cen_x, cen_y, s, c);
      sin_cos(32'(64'(dt) * 64'(spd_x)), s, c);
      for (int i = 0; i < NUM_VERTICES; i++) turn_pair(vy[i], vz[i], cen_y, cen_z, s, c);
      sin_cos(32'(64'(dt) * 64'(spd_y)), s, c);
      for (int i = 0; i < NUM_VERTICES; i++) turn_pair(vz[i], vx[i], cen_z, cen_x, s, c);
      for (int i = 0; i < NUM_VERTICES; i++) begin
         e.idx  = 3'(i);
         e.x    = vx[i];
         e.y    = vy[i];
         e.z    = vz[i];
         e.last = (i == NUM_VERTICES - 1);
         rotated_q.push_back(e);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      vertex_rsp_type e;
      if (reset) begin
         fail_count = 0;
         rotated_q.delete();
         cen_x = 32'sd32768000;
         cen_y = 32'sd32768000;
         cen_z = 32'sd0;
         spd_x = 32'd214748;
         spd_y = 32'd644245;
         spd_z = 32'd429497;
         for (int i = 0; i < NUM_VERTICES; i++) begin
            vx[i] = (i % 8 == 0 || i % 8 == 3 || i % 8 == 4 || i % 8 == 7) ? 250 * 65536 : 750 * 65536;
            vy[i] = (i % 8 == 0 || i % 8 == 1 || i % 8 == 4 || i % 8 == 5) ? 250 * 65536 : 750 * 65536;
            vz[i] = (i % 8 < 4) ? -250 * 65536 : 250 * 65536;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: cen_x = csr_data;
               CSR_CENTER_Y: cen_y = csr_data;
               CSR_CENTER_Z: cen_z = csr_data;
               CSR_SPEED_X:  spd_x = csr_data;
               CSR_SPEED_Y:  spd_y = csr_data;
               CSR_SPEED_Z:  spd_z = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (rotated_q.size() == 0) begin
               report_mismatch("unexpected vertex", 32'(rsp_out_index), 32'd0);
            end else begin
               e = rotated_q.pop_front();
               if (rsp_out_index !== e.idx) report_mismatch("index", 32'(rsp_out_index), 32'(e.idx));
               if (rsp_out_x !== e.x) report_mismatch("x", rsp_out_x, e.x);
               if (rsp_out_y !== e.y) report_mismatch("y", rsp_out_y, e.y);
               if (rsp_out_z !== e.z) report_mismatch("z", rsp_out_z, e.z);
               if (rsp_last_vertex !== e.last)
                  report_mismatch("last flag", 32'(rsp_last_vertex), 32'(e.last));
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == REQ_TICK) begin
               rotate_all(req_time_delta_ms);
            end else if (32'(req_vertex_index) < NUM_VERTICES) begin
               vx[req_vertex_index] = req_load_x;
               vy[req_vertex_index] = req_load_y;
               vz[req_vertex_index] = req_load_z;
            end
         end
      end
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex set Euler rotator testbench
// Drives loads, ticks and register writes into the rotator under random
// idling on both sides, with a long result stall and a drain pause, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
   import vser_pkg::*;

   localparam logic       REQ_LOAD   = 1'b0;
   localparam logic       REQ_TICK   = 1'b1;
   localparam logic [2:0] CSR_SPARE6 = 3'd6;
   localparam logic [2:0] CSR_SPARE7 = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = REQ_LOAD;
   logic [2:0]         req_vertex_index = '0;
   logic signed [31:0] req_load_x = '0;
   logic signed [31:0] req_load_y = '0;
   logic signed [31:0] req_load_z = '0;
   logic [15:0]        req_time_delta_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_out_index;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic               rsp_last_vertex;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;
   int                 fail_count;
   int                 pending;
   int                 tx_idle_pct = 0;
   int                 rx_idle_pct = 0;
   logic               hold_off = 1'b0;

   always #6 clock = ~clock;

   vertex_set_euler_rotator dut (.*);

   vertex_rotation_checker checker_i (.*);

   // receiver: random idling, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
         repeat (4000) @(posedge clock);
         hold_off = 1'b0;
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   initial begin
      #60ms;
      $display("simulation failed");
      $finish;
   end

   task automatic send_item(input logic kind, input logic [2:0] idx,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [15:0] dt);
      int gap;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_vertex_index  <= idx;
      req_load_x        <= x;
      req_load_y        <= y;
      req_load_z        <= z;
      req_time_delta_ms <= dt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold until every expected vertex is out and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] coord();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom();
         default: return 32'($urandom_range(0, 1000) << 16) + 32'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [31:0] speed();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         default: return $urandom_range(1, 2000000);
      endcase
   endfunction

   task automatic random_items(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 35)
            send_item(REQ_TICK, 3'($urandom()), coord(), coord(), coord(),
                      ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 50)));
         else
            send_item(REQ_LOAD, 3'($urandom()), coord(), coord(), coord(), 16'($urandom()));
      end
   endtask

   task automatic random_config();
      write_reg(CSR_CENTER_X, coord());
      write_reg(CSR_CENTER_Y, coord());
      write_reg(CSR_CENTER_Z, coord());
      write_reg(CSR_SPEED_X, speed());
      write_reg(CSR_SPEED_Y, speed());
      write_reg(CSR_SPEED_Z, speed());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset cube, zero delta, extremes, wrap-around, spare registers
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'd0);
      send_item(REQ_TICK, 3'd7, '0, '0, '0, 16'd1);
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'hFFFF);
      send_item(REQ_LOAD, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
      send_item(REQ_LOAD, 3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
      send_item(REQ_LOAD, 3'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, '0);
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'd100);
      drain();
      write_reg(CSR_CENTER_X, 32'h8000_0000);
      write_reg(CSR_CENTER_Y, 32'h7FFF_FFFF);
      write_reg(CSR_CENTER_Z, 32'h8000_0000);
      write_reg(CSR_SPEED_X, 32'hFFFF_FFFF);
      write_reg(CSR_SPEED_Y, 32'h4000_0000);
      write_reg(CSR_SPEED_Z, 32'h2000_0000);
      write_reg(CSR_SPARE6, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE7, 32'h1234_5678);
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'd1);
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'd3);
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'hFFFF);
      drain();
      write_reg(CSR_CENTER_X, 32'h7FFF_FFFF);
      write_reg(CSR_CENTER_Y, 32'h8000_0000);
      write_reg(CSR_CENTER_Z, 32'h7FFF_FFFF);
      write_reg(CSR_SPEED_X, 32'd0);
      write_reg(CSR_SPEED_Y, 32'd0);
      write_reg(CSR_SPEED_Z, 32'hC000_0001);
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'd1);
      send_item(REQ_TICK, 3'd0, '0, '0, '0, 16'd2);
      drain();

      tx_idle_pct = 31;
      rx_idle_pct = 87;
      random_config();
      random_items(115);
      drain();

      tx_idle_pct = 87;
      rx_idle_pct = 31;
      random_config();
      random_items(115);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_config();
      hold_off = 1'b1;
      random_items(60);
      // pause the sender until every vertex has come back
      drain();
      random_items(60);
      drain();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/vser_pkg.sv
hdl/vser_mul.sv
hdl/vser_vram.sv
hdl/vser_trig.sv
hdl/vertex_set_euler_rotator.sv
tb/vertex_rotation_checker.sv
tb/testbench.sv
